// ----- sv/rrc_pkg.sv -----
// rrc_pkg: shared constants for the rational reconstruction unit
// status codes, stream and apb widths, register indexes and result field layout
// no dependencies
package rrc_pkg;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_COF   = 2'd1;
  localparam logic [1:0] ST_DEN_BIG  = 2'd2;
  localparam logic [1:0] ST_NOT_COPR = 2'd3;

  // field widths
  localparam int RES_W  = 64;
  localparam int STAT_W = 2;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 63;
  localparam int CFG_W  = 63;

  // stream beat widths, padded to whole bytes
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 136;

  // result beat layout, lowest bit up
  localparam int NUM_LSB = STAT_W;
  localparam int DEN_LSB = STAT_W + NUM_W;
  localparam int PAD_LSB = STAT_W + NUM_W + DEN_W;

  // apb port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;

  // register index, taken from paddr[3]
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_BOUND   = 1'b1;

endpackage

// ----- sv/rational_reconstruction_unit.sv -----
// rational_reconstruction_unit: top level of the rational reconstruction block
// depends on rrc_pkg and rrc_div
//
// Takes a signed residue beat, reduces it modulo the configured modulus, and
// runs the extended Euclidean algorithm until the remainder is no larger than
// recon_bound, then returns remainder/cofactor with the sign on the numerator,
// checked for a nonzero cofactor, a denominator within the bound and
// coprimality. One item is worked at a time: s_tready is high only while the
// sequencer is idle. All divisions and multiplications go through one shared
// bit-serial divider; the Euclid and the gcd loop each run at most about 90
// steps at 64 bits, and a zero modulus skips the divider. The result waits in
// an output register until taken. Registers: modulus at byte address 0,
// recon_bound at 8, both 63 bits; they are to be written only while the block
// is idle, a rule on the user that the block itself does not enforce.
module rational_reconstruction_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream: [63:0] residue
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rrc_pkg::S_DATA_W-1:0]    s_tdata,
  // result stream: [1:0] status, [65:2] numerator, [128:66] denominator, rest zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rrc_pkg::M_DATA_W-1:0]    m_tdata,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rrc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rrc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int W = WORD_BITS;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_REDUCE = 8'b0000_0010,  // residue mod m in the divider
    S_ECHK   = 8'b0000_0100,  // test remainder against bound
    S_EDIV   = 8'b0000_1000,  // one euclid step in the divider
    S_FCHK   = 8'b0001_0000,  // cofactor and bound checks
    S_GCHK   = 8'b0010_0000,  // gcd loop test
    S_GDIV   = 8'b0100_0000,  // one gcd step in the divider
    S_OUT    = 8'b1000_0000   // hand result to output register
  } state_t;

  state_t state;

  // configuration registers
  logic [rrc_pkg::CFG_W-1:0] modulus;
  logic [rrc_pkg::CFG_W-1:0] recon_bound;

  // working registers
  logic [W-1:0] bnd;
  logic [W-1:0] mval;
  logic         neg;
  logic [W-1:0] r0;
  logic [W-1:0] r1;
  logic [W-1:0] t0;
  logic [W-1:0] t1;
  logic [W-1:0] anum;
  logic         aneg;
  logic [W-1:0] dmag;

  // pending result
  logic [1:0]                res_status;
  logic [rrc_pkg::NUM_W-1:0] res_num;
  logic [rrc_pkg::DEN_W-1:0] res_den;

  // output register
  logic [1:0]                out_status;
  logic [rrc_pkg::NUM_W-1:0] out_num;
  logic [rrc_pkg::DEN_W-1:0] out_den;

  // divider hookup
  logic         div_start;
  logic [W-1:0] div_dvd;
  logic [W-1:0] div_dvs;
  logic [W-1:0] div_mop;
  logic         div_done;
  logic [W-1:0] div_rem;
  logic [W-1:0] div_prod;

  // input decode
  logic         in_acc;
  logic [W-1:0] in_ux;
  logic         in_neg;
  logic [W-1:0] in_mag;
  logic [W-1:0] cfg_m;
  logic [W-1:0] cfg_b;
  logic         cfg_wr;

  // final-step helpers
  logic         t1_neg;
  logic [W-1:0] t1_mag;
  logic [W-1:0] red_r;
  logic [W-1:0] num_signed;

  // ---------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= rrc_pkg::CFG_W'(1);
      recon_bound <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        rrc_pkg::REG_MODULUS: modulus     <= pwdata[rrc_pkg::CFG_W-1:0];
        rrc_pkg::REG_BOUND:   recon_bound <= pwdata[rrc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      rrc_pkg::REG_MODULUS: prdata = {1'b0, modulus};
      rrc_pkg::REG_BOUND:   prdata = {1'b0, recon_bound};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // input side: residue taken as low W bits, two's complement
  // ---------------------------------------------------------------------
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign in_ux    = s_tdata[W-1:0];
  assign in_neg   = in_ux[W-1];
  assign in_mag   = in_neg ? (~in_ux + 1'b1) : in_ux;
  // modulus and bound use their low W-1 bits
  assign cfg_m    = {1'b0, modulus[W-2:0]};
  assign cfg_b    = {1'b0, recon_bound[W-2:0]};

  // ---------------------------------------------------------------------
  // shared divider; operands chosen by state
  // ---------------------------------------------------------------------
  always_comb begin
    if (state == S_IDLE) begin
      div_dvd = in_mag;
      div_dvs = cfg_m;
      div_mop = '0;
    end else begin
      div_dvd = r0;
      div_dvs = r1;
      div_mop = t1;
    end
    div_start = 1'b0;
    case (state)
      S_IDLE:  div_start = in_acc & (cfg_m != '0);
      S_ECHK:  div_start = (r1 > bnd) & (r1 != '0);
      S_GCHK:  div_start = (r1 != '0);
      default: div_start = 1'b0;
    endcase
  end

  rrc_div #(
    .W (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .mop      (div_mop),
    .done     (div_done),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  // true mod: a negative residue with nonzero remainder folds to m - r
  assign red_r      = (neg && (div_rem != '0)) ? (mval - div_rem) : div_rem;
  // sign of the cofactor moves to the numerator
  assign t1_neg     = t1[W-1];
  assign t1_mag     = t1_neg ? (~t1 + 1'b1) : t1;
  assign num_signed = aneg ? (~anum + 1'b1) : anum;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cfg_m == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (div_done) state <= S_ECHK;
        end
        S_ECHK: begin
          if (r1 > bnd) begin
            // zero remainder in the loop ends with no cofactor
            state <= (r1 == '0) ? S_OUT : S_EDIV;
          end else begin
            state <= S_FCHK;
          end
        end
        S_EDIV: begin
          if (div_done) state <= S_ECHK;
        end
        S_FCHK: begin
          if (t1 == '0 || t1_mag > bnd) begin
            state <= S_OUT;
          end else begin
            state <= S_GCHK;
          end
        end
        S_GCHK: begin
          state <= (r1 != '0) ? S_GDIV : S_OUT;
        end
        S_GDIV: begin
          if (div_done) state <= S_GCHK;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          mval       <= cfg_m;
          bnd        <= cfg_b;
          neg        <= in_neg;
          // zero modulus fails at once
          res_status <= rrc_pkg::ST_NO_COF;
          res_num    <= '0;
          res_den    <= '0;
        end
      end
      S_REDUCE: begin
        if (div_done) begin
          r0 <= mval;
          r1 <= red_r;
          t0 <= '0;
          t1 <= W'(1);
        end
      end
      S_ECHK: begin
        if (r1 > bnd && r1 == '0) begin
          res_status <= rrc_pkg::ST_NO_COF;
          res_num    <= '0;
          res_den    <= '0;
        end
      end
      S_EDIV: begin
        if (div_done) begin
          r0 <= r1;
          r1 <= div_rem;
          t0 <= t1;
          t1 <= t0 - div_prod;
        end
      end
      S_FCHK: begin
        res_num <= '0;
        res_den <= '0;
        if (t1 == '0) begin
          res_status <= rrc_pkg::ST_NO_COF;
        end else if (t1_mag > bnd) begin
          res_status <= rrc_pkg::ST_DEN_BIG;
        end
        anum <= r1;
        aneg <= t1_neg;
        dmag <= t1_mag;
        // gcd(|r|, |t|) runs in r0/r1
        r0   <= r1;
        r1   <= t1_mag;
      end
      S_GCHK: begin
        if (r1 == '0) begin
          if (r0 == W'(1)) begin
            res_status <= rrc_pkg::ST_OK;
            res_num    <= rrc_pkg::NUM_W'(signed'(num_signed));
            res_den    <= rrc_pkg::DEN_W'(dmag);
          end else begin
            res_status <= rrc_pkg::ST_NOT_COPR;
            res_num    <= '0;
            res_den    <= '0;
          end
        end
      end
      S_GDIV: begin
        if (div_done) begin
          r0 <= r1;
          r1 <= div_rem;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // output register, parts the sequencer from the result consumer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      out_status <= res_status;
      out_num    <= res_num;
      out_den    <= res_den;
    end
  end

  assign m_tdata = {{(rrc_pkg::M_DATA_W - rrc_pkg::PAD_LSB){1'b0}},
                    out_den, out_num, out_status};

endmodule

// ----- sv/rrc_div.sv -----
// rrc_div: bit-serial restoring divider with a fused shift-add multiply
// gives the remainder of dividend / divisor and the quotient times mop, modulo 2^W
// uses no package
module rrc_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  input  logic [W-1:0] mop,
  output logic         done,
  output logic [W-1:0] rem,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  dvd;
  logic [W-1:0]  dvs;
  logic [W-1:0]  mul;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [W:0]    trial;
  logic          qbit;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  prod_next;

  always_comb begin
    trial     = {rem, dvd[W-1]} - {1'b0, dvs};
    qbit      = ~trial[W];
    rem_next  = qbit ? trial[W-1:0] : {rem[W-2:0], dvd[W-1]};
    prod_next = {prod[W-2:0], 1'b0} + (qbit ? mul : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      mul  <= mop;
      rem  <= '0;
      prod <= '0;
    end else if (busy) begin
      dvd  <= {dvd[W-2:0], 1'b0};
      rem  <= rem_next;
      prod <= prod_next;
    end
  end

endmodule

// ----- sv/rrc_chk.sv -----
// rrc_chk: port-level checks for rational_reconstruction_unit
// depends on rrc_pkg; bound to the top level at the end of this file
module rrc_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rrc_pkg::M_DATA_W-1:0]   m_tdata,
  input logic                           pready
);

  // one item at a time: ready drops after an accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed under stall");

  // a failing status carries zero numerator and denominator
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != rrc_pkg::ST_OK |->
      m_tdata[rrc_pkg::PAD_LSB-1:rrc_pkg::NUM_LSB] == '0)
    else $error("failed result with nonzero fraction");

  // a good result has a nonzero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == rrc_pkg::ST_OK |->
      m_tdata[rrc_pkg::PAD_LSB-1:rrc_pkg::DEN_LSB] != '0)
    else $error("good result with zero denominator");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind rational_reconstruction_unit rrc_chk u_rrc_chk (.*);

// ----- tb/sv/tb_rational_reconstruction_unit.sv -----
// tb_rational_reconstruction_unit: self-checking stream testbench for the rational
// reconstruction unit; predicts each result in a local model and scores every beat
// depends on rrc_pkg and rational_reconstruction_unit
`timescale 1ns / 100ps

module tb_rational_reconstruction_unit;

  // one result beat, unpacked from m_tdata
  typedef struct packed {
    logic [rrc_pkg::STAT_W-1:0] status;
    logic [rrc_pkg::NUM_W-1:0]  num;
    logic [rrc_pkg::DEN_W-1:0]  den;
  } recon_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  // worst item: up to ~180 divisions; add the long receiver hold and the longest
  // sender gap, then take the sum about 3x
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int LONG_HOLD      = 20000;
  localparam int TAIL_CYCLES    = 100;

  localparam logic [rrc_pkg::CFG_W-1:0] CFG_MAX       = {rrc_pkg::CFG_W{1'b1}};
  localparam logic [rrc_pkg::CFG_W-1:0] MERSENNE_61   = 63'h1fff_ffff_ffff_ffff;
  localparam logic [rrc_pkg::CFG_W-1:0] TWO_PRIME_MOD = 63'd1000000007 * 63'd998244353;

  // dut ports; the inputs are all known from time zero
  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rrc_pkg::S_DATA_W-1:0]   s_tdata  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [rrc_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [rrc_pkg::APB_ADDR_W-1:0] paddr    = '0;
  logic [rrc_pkg::APB_DATA_W-1:0] pwdata   = '0;
  logic [rrc_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // shadow of the two registers, updated as each write lands
  logic [rrc_pkg::CFG_W-1:0] cfg_modulus = 63'd1;
  logic [rrc_pkg::CFG_W-1:0] cfg_bound   = 63'd0;

  logic [rrc_pkg::RES_W-1:0] residue_q[$];   // residues waiting for the sender
  recon_t                    recon_q[$];     // predicted results, oldest first

  int residues_queued = 0;
  int residues_sent   = 0;
  int results_seen    = 0;
  int errors          = 0;
  int status_seen[4]  = '{0, 0, 0, 0};

  // sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;

  // receiver stall shaping
  bit       hold_req     = 1'b0;
  bit       hold_started = 1'b0;
  int       hold_left    = 0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_left      = 0;

  rational_reconstruction_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // predicted reconstruction of one residue under the given register values
  function automatic recon_t reconstruct(logic [rrc_pkg::RES_W-1:0] residue,
                                         logic [rrc_pkg::CFG_W-1:0] modulus,
                                         logic [rrc_pkg::CFG_W-1:0] bound);
    logic [63:0] m, bnd, mag, r0, r1, r2, t0, t1, t2, q, a_mag, b_mag, ga, gb, gt;
    logic        neg, a_neg;
    recon_t      res;
    res.status = rrc_pkg::ST_NO_COF;
    res.num    = '0;
    res.den    = '0;
    m   = {1'b0, modulus};
    bnd = {1'b0, bound};
    if (m == 0) return res;
    // true mod: fold negative residues back into 0..m-1, most negative one included
    neg = residue[rrc_pkg::RES_W-1];
    mag = neg ? -residue : residue;
    r1  = mag % m;
    if (neg && r1 != 0) r1 = m - r1;
    r0 = m;
    t0 = '0;
    t1 = 64'd1;
    // r1 > bnd >= 0 keeps the divisor nonzero, so no zero-remainder exit here
    while (r1 > bnd) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = t0 - q * t1;
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    if (t1 == 0) return res;
    // cofactor sign goes onto the numerator
    a_mag = r1;
    a_neg = t1[63];
    b_mag = a_neg ? -t1 : t1;
    if (b_mag > bnd) begin
      res.status = rrc_pkg::ST_DEN_BIG;
      return res;
    end
    ga = a_mag;
    gb = b_mag;
    while (gb != 0) begin
      gt = ga % gb;
      ga = gb;
      gb = gt;
    end
    // a zero numerator only passes over a denominator of one
    if (ga != 1) begin
      res.status = rrc_pkg::ST_NOT_COPR;
      return res;
    end
    res.status = rrc_pkg::ST_OK;
    res.num    = a_neg ? -a_mag : a_mag;
    res.den    = b_mag[rrc_pkg::DEN_W-1:0];
    return res;
  endfunction

  // inverse of b mod m, b coprime to m
  function automatic logic [63:0] inverse_mod(logic [63:0] b, logic [63:0] m);
    logic signed [127:0] r0, r1, s0, s1, q, tmp;
    r0 = 128'(m);
    r1 = 128'(b);
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      q   = r0 / r1;
      tmp = r0 - q * r1;
      r0  = r1;
      r1  = tmp;
      tmp = s0 - q * s1;
      s0  = s1;
      s1  = tmp;
    end
    if (s0 < 0) s0 = s0 + 128'(m);
    return s0[63:0];
  endfunction

  // residue that encodes a random small fraction a/b under a prime-ish modulus
  function automatic logic [rrc_pkg::RES_W-1:0] encode_fraction(logic [63:0] m,
                                                                int unsigned bnd);
    logic [127:0]              a, b, prod;
    logic [rrc_pkg::RES_W-1:0] r;
    case ($urandom_range(0, 4))
      0:       b = 128'd1;
      default: b = 128'($urandom_range(1, bnd));
    endcase
    a    = ($urandom_range(0, 5) == 0) ? 128'd0 : 128'($urandom_range(0, bnd));
    prod = (a % m) * inverse_mod(b[63:0], m) % m;
    r    = prod[63:0];
    if ($urandom_range(0, 1) == 1) r = (m - r) % m;
    // sometimes hand over the negative representative instead
    if ($urandom_range(0, 2) == 0) r = r - m;
    return r;
  endfunction

  task automatic offer(input logic [rrc_pkg::RES_W-1:0] residue);
    residue_q.push_back(residue);
    residues_queued++;
  endtask

  task automatic queue_random(input int count, input bit fractions);
    logic [rrc_pkg::RES_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      if (fractions && $urandom_range(0, 3) != 0)
        v = encode_fraction({1'b0, cfg_modulus}, cfg_bound[31:0]);
      else
        v = {$urandom, $urandom};
      offer(v);
    end
  endtask

  // sender pause: nothing new until every predicted result has come back
  task automatic wait_for_results();
    while (results_seen < residues_queued) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle; the register takes it on the access edge
  task automatic cfg_write(input logic reg_sel, input logic [rrc_pkg::CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == rrc_pkg::REG_MODULUS) begin
      cfg_modulus = value;
    end else begin
      cfg_bound = value;
    end
  endtask

  // sender: bursts of residue beats with random gaps, beat held until taken
  always @(posedge clk) begin : sender
    logic taken;
    taken = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (taken) begin
        // registers only change while idle, so the shadow is current here
        recon_q.push_back(reconstruct(s_tdata, cfg_modulus, cfg_bound));
        residues_sent++;
      end
      if (s_tvalid && !taken) begin
        // beat still on offer, keep it steady
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (residue_q.size() > 0) begin
        s_tdata  <= residue_q.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between open, coin-flip and sparse stretches;
  // one long hold-off on request lets the block back up into its input
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req && !hold_started) begin
        hold_left    = LONG_HOLD;
        hold_started = 1'b1;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 400);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: m_tready <= 1'b1;
          RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // scoreboard: each result beat against the oldest prediction, field by field
  always @(posedge clk) begin : scoreboard
    recon_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[rrc_pkg::STAT_W-1:0];
      got.num    = m_tdata[rrc_pkg::NUM_LSB +: rrc_pkg::NUM_W];
      got.den    = m_tdata[rrc_pkg::DEN_LSB +: rrc_pkg::DEN_W];
      results_seen++;
      status_seen[got.status]++;
      if (recon_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing predicted: status %0d num %0d den %0d",
                 $time, got.status, $signed(got.num), got.den);
      end else begin
        want = recon_q.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.num !== want.num) begin
          errors++;
          $display("%0t: numerator expected %0d actual %0d",
                   $time, $signed(want.num), $signed(got.num));
        end
        if (got.den !== want.den) begin
          errors++;
          $display("%0t: denominator expected %0d actual %0d", $time, want.den, got.den);
        end
      end
    end
  end

  // watchdog: only counts while work is outstanding and no beat moves
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          results_seen >= residues_queued)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset registers: modulus one, bound zero, so every residue lands on 0/1
    // with the denominator over the bound
    offer(64'd0);
    offer(64'h8000_0000_0000_0000);
    offer(64'h7fff_ffff_ffff_ffff);
    wait_for_results();

    // zero modulus cannot reduce anything
    cfg_write(rrc_pkg::REG_MODULUS, '0);
    cfg_write(rrc_pkg::REG_BOUND, '0);
    offer(64'd1);
    offer(64'hffff_ffff_ffff_ffff);
    wait_for_results();

    // both registers at their top: no Euclid step, result is the reduced residue over one
    cfg_write(rrc_pkg::REG_MODULUS, CFG_MAX);
    cfg_write(rrc_pkg::REG_BOUND, CFG_MAX);
    offer(64'd0);
    offer(64'hffff_ffff_ffff_ffff);
    offer(64'h8000_0000_0000_0000);
    offer(64'h7fff_ffff_ffff_ffff);
    offer(64'h5555_5555_5555_5555);
    offer(64'haaaa_aaaa_aaaa_aaaa);
    wait_for_results();

    // tiny modulus: common factor, zero numerator over two, negative numerator
    cfg_write(rrc_pkg::REG_MODULUS, 63'd10);
    cfg_write(rrc_pkg::REG_BOUND, 63'd3);
    offer(64'd4);
    offer(64'd5);
    offer(64'd7);
    offer(-64'sd3);
    offer(64'd6);
    wait_for_results();

    // bound of one: denominator too large, plus zero over one
    cfg_write(rrc_pkg::REG_BOUND, 63'd1);
    offer(64'd3);
    offer(64'd1);
    offer(-64'sd9);
    offer(64'd0);
    wait_for_results();

    // random: small prime with its natural bound, encoded fractions plus noise
    cfg_write(rrc_pkg::REG_MODULUS, 63'd65521);
    cfg_write(rrc_pkg::REG_BOUND, 63'd180);
    queue_random(30, 1'b1);
    wait_for_results();

    // random: 61-bit prime; the receiver holds off long while the sender keeps going
    cfg_write(rrc_pkg::REG_MODULUS, MERSENNE_61);
    cfg_write(rrc_pkg::REG_BOUND, 63'd1073741824);
    queue_random(20, 1'b1);
    hold_req = 1'b1;
    wait_for_results();

    // random: product of two primes near 2^30
    cfg_write(rrc_pkg::REG_MODULUS, TWO_PRIME_MOD);
    cfg_write(rrc_pkg::REG_BOUND, 63'd706000000);
    queue_random(20, 1'b1);
    wait_for_results();

    // random: wide odd modulus with a small bound, long Euclid runs
    cfg_write(rrc_pkg::REG_MODULUS, rrc_pkg::CFG_W'({$urandom, $urandom} | 64'd1));
    cfg_write(rrc_pkg::REG_BOUND, rrc_pkg::CFG_W'($urandom_range(0, 300)));
    queue_random(12, 1'b0);
    wait_for_results();

    // random: small arbitrary moduli, all statuses turn up
    for (int k = 0; k < 2; k++) begin
      cfg_write(rrc_pkg::REG_MODULUS, rrc_pkg::CFG_W'($urandom_range(2, 5000)));
      cfg_write(rrc_pkg::REG_BOUND, rrc_pkg::CFG_W'($urandom_range(0, 70)));
      queue_random(10, 1'b0);
      wait_for_results();
    end

    // let any stray beat show up before scoring
    repeat (TAIL_CYCLES) @(posedge clk);
    if (recon_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, recon_q.size());
    end

    $display("covered %0d residues over reset, zero, full-range and eight working settings",
             residues_sent);
    $display("results %0d: ok %0d, no cofactor %0d, denominator too big %0d, not coprime %0d",
             results_seen, status_seen[rrc_pkg::ST_OK], status_seen[rrc_pkg::ST_NO_COF],
             status_seen[rrc_pkg::ST_DEN_BIG], status_seen[rrc_pkg::ST_NOT_COPR]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rrc_pkg.sv
sv/rrc_div.sv
sv/rational_reconstruction_unit.sv
sv/rrc_chk.sv
tb/sv/tb_rational_reconstruction_unit.sv
